>>> hdl/assert_macros.svh
// assertion macros for the packetizer checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLKD(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// property checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

>>> hdl/rtpk_pkg.sv
package rtpk_pkg;

   localparam int SIZE_WIDTH  = 20;
   localparam int QUEUE_DEPTH = 4;

   // frame kinds
   localparam logic [1:0] OP_PARAMS = 2'd0;
   localparam logic [1:0] OP_VIDEO  = 2'd1;
   localparam logic [1:0] OP_AUDIO  = 2'd2;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_STREAM_ENABLE    = 2'd0,
      REG_INTERLEAVED_MODE = 2'd1,
      REG_SSRC_VALUE       = 2'd2
   } reg_index_type;

   localparam logic [7:0] RTP_VERSION   = 8'h80;
   localparam logic [7:0] PT_VIDEO      = 8'h60;
   localparam logic [7:0] PT_AUDIO      = 8'h61;
   localparam logic [7:0] FU_TYPE       = 8'h1C;
   localparam logic [7:0] FU_START      = 8'h80;
   localparam logic [7:0] FU_END        = 8'h40;
   localparam logic [7:0] CHAN_VIDEO    = 8'h00;
   localparam logic [7:0] CHAN_AUDIO    = 8'h02;
   localparam logic [7:0] PREFIX_MARK   = 8'h24;
   localparam logic [7:0] AU_HDR_LEN_HI = 8'h00;
   localparam logic [7:0] AU_HDR_LEN_LO = 8'h10;
   localparam logic [15:0] RTP_HDR_LEN  = 16'd12;
   localparam logic [15:0] AAC_HDR_LEN  = 16'd16;
   localparam logic [15:0] FU_HDR_LEN   = 16'd14;

   typedef struct packed {
      logic [1:0]            operation;
      logic [7:0]            payload_byte;
      logic                  frame_start;
      logic [SIZE_WIDTH-1:0] frame_size;
      logic [31:0]           frame_timestamp;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       packet_start;
      logic       packet_end;
      logic       last_of_run;
   } rsp_type;

   // one classified request: optional headers, then one payload byte
   typedef struct packed {
      logic        hdr;
      logic        aac;
      logic        fu;
      logic        audio;
      logic        pend;
      logic [15:0] seq;
      logic [31:0] ts;
      logic [15:0] len;
      logic [12:0] au_size;
      logic [7:0]  fu_ind;
      logic [7:0]  fu_hdr;
      logic [7:0]  data;
   } job_type;

endpackage

>>> hdl/rtp_h264_aac_packetizer.sv
// results pass through the queue and the back end's output register; throughput:
// one result per cycle unless rsp stalls; a request gives 0 to 21 results, set by
// the back end's byte sequencer draining a 4-entry request queue; payload bytes
// sustain 1/cycle; header bursts (12 to 20 bytes) stall req once the queue fills
// reset: synchronous, active high; counters, frame state, queue and output valid
// cleared, registers go to enable 0, interleaved 1, ssrc 0
module rtp_h264_aac_packetizer #(
   parameter int FRAGMENT_PAYLOAD = 1262
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  rtpk_pkg::req_type req_data,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rtpk_pkg::rsp_type rsp_data,
   // register port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import rtpk_pkg::*;

   // configuration registers
   logic          enable_ff, enable_in;
   logic          interleave_ff, interleave_in;
   logic [31:0]   ssrc_ff, ssrc_in;
   logic          cfg_write;
   reg_index_type cfg_index;

   // front to queue to back
   logic    req_accept;
   logic    push;
   job_type push_job;
   logic    pop;
   job_type head;
   logic    head_valid;
   logic    queue_full;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign cfg_index = reg_index_type'(paddr[3:2]);

   always_comb begin
      enable_in     = enable_ff;
      interleave_in = interleave_ff;
      ssrc_in       = ssrc_ff;
      if (cfg_write) begin
         unique case (cfg_index)
            REG_STREAM_ENABLE:    enable_in     = pwdata[0];
            REG_INTERLEAVED_MODE: interleave_in = pwdata[0];
            REG_SSRC_VALUE:       ssrc_in       = pwdata;
            default: begin
            end
         endcase
      end
   end

   // register readback
   always_comb begin
      unique case (cfg_index)
         REG_STREAM_ENABLE:    prdata = {31'd0, enable_ff};
         REG_INTERLEAVED_MODE: prdata = {31'd0, interleave_ff};
         REG_SSRC_VALUE:       prdata = ssrc_ff;
         default:              prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         interleave_ff <= 1'b1;
         ssrc_ff       <= '0;
      end else begin
         enable_ff     <= enable_in;
         interleave_ff <= interleave_in;
         ssrc_ff       <= ssrc_in;
      end
   end

   // input side only waits on queue room, never on the result channel directly
   assign req_stall  = queue_full;
   assign req_accept = req_valid && !req_stall;

   // front: classify each request, track frame and fragment state, count sequences
   rtpk_front #(
      .FRAGMENT_PAYLOAD(FRAGMENT_PAYLOAD)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .req          (req_data),
      .stream_enable(enable_ff),
      .push         (push),
      .job          (push_job)
   );

   // short queue decouples classification from byte emission
   rtpk_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .wr_job    (push_job),
      .pop       (pop),
      .head      (head),
      .head_valid(head_valid),
      .full      (queue_full)
   );

   // back: walks any prefix, rtp header and au or fu bytes, then the payload byte
   rtpk_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .head_valid      (head_valid),
      .interleaved_mode(interleave_ff),
      .ssrc_value      (ssrc_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data        (rsp_data)
   );

endmodule

>>> hdl/rtpk_front.sv
module rtpk_front #(
   parameter int FRAGMENT_PAYLOAD = 1262
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  rtpk_pkg::req_type req,
   input  logic             stream_enable,
   output logic             push,
   output rtpk_pkg::job_type job
);
   import rtpk_pkg::*;

   localparam int FW = $clog2(FRAGMENT_PAYLOAD + 1);

   logic [15:0]           vseq_ff, vseq_in;
   logic [15:0]           aseq_ff, aseq_in;
   logic                  params_ff, params_in;
   logic [7:0]            nal_ff, nal_in;
   logic [SIZE_WIDTH-1:0] left_ff, left_in;
   logic [FW-1:0]         fill_ff, fill_in;
   logic                  first_ff, first_in;
   logic                  frag_ff, frag_in;
   logic [31:0]           ts_ff, ts_in;

   always_comb begin
      logic [SIZE_WIDTH-1:0] size;
      logic [SIZE_WIDTH-1:0] left_dec;
      logic [FW-1:0]         fill_nx;
      logic                  last_frag;
      logic                  frag_end;
      logic [15:0]           flen;
      size      = req.frame_size;
      left_dec  = left_ff - SIZE_WIDTH'(1);
      fill_nx   = fill_ff + FW'(1);
      last_frag = left_ff <= SIZE_WIDTH'(FRAGMENT_PAYLOAD);
      frag_end  = (left_dec == '0) || (fill_nx >= FW'(FRAGMENT_PAYLOAD));
      flen      = last_frag ? left_ff[15:0] : 16'(FRAGMENT_PAYLOAD);
      vseq_in   = vseq_ff;
      aseq_in   = aseq_ff;
      params_in = params_ff;
      nal_in    = nal_ff;
      left_in   = left_ff;
      fill_in   = fill_ff;
      first_in  = first_ff;
      frag_in   = frag_ff;
      ts_in     = ts_ff;
      push      = 1'b0;
      job       = '0;
      job.data  = req.payload_byte;
      job.ts    = ts_ff;
      if (accept) begin
         if (!stream_enable) begin
            left_in  = '0;
            fill_in  = '0;
            first_in = 1'b0;
            frag_in  = 1'b0;
         end else if (req.frame_start) begin
            left_in  = '0;
            fill_in  = '0;
            first_in = 1'b0;
            frag_in  = 1'b0;
            ts_in    = req.frame_timestamp;
            job.ts   = req.frame_timestamp;
            job.pend = size == SIZE_WIDTH'(1);
            unique case (req.operation)
               OP_PARAMS: begin
                  params_in = 1'b1;
                  if (size != '0) begin
                     vseq_in = vseq_ff + 16'd1;
                     push    = 1'b1;
                     job.hdr = 1'b1;
                     job.seq = vseq_in;
                     job.len = 16'(size) + RTP_HDR_LEN;
                     left_in = size - SIZE_WIDTH'(1);
                  end
               end
               OP_VIDEO: begin
                  if (params_ff && size != '0) begin
                     if (size <= SIZE_WIDTH'(FRAGMENT_PAYLOAD)) begin
                        vseq_in = vseq_ff + 16'd1;
                        push    = 1'b1;
                        job.hdr = 1'b1;
                        job.seq = vseq_in;
                        job.len = 16'(size) + RTP_HDR_LEN;
                        left_in = size - SIZE_WIDTH'(1);
                     end else begin
                        // large unit: keep the nal header, emit nothing now
                        nal_in   = req.payload_byte;
                        left_in  = size - SIZE_WIDTH'(1);
                        frag_in  = 1'b1;
                        first_in = 1'b1;
                     end
                  end
               end
               OP_AUDIO: begin
                  if (params_ff && size != '0) begin
                     aseq_in     = aseq_ff + 16'd1;
                     push        = 1'b1;
                     job.hdr     = 1'b1;
                     job.aac     = 1'b1;
                     job.audio   = 1'b1;
                     job.seq     = aseq_in;
                     job.len     = 16'(size) + AAC_HDR_LEN;
                     job.au_size = size[12:0];
                     left_in     = size - SIZE_WIDTH'(1);
                  end
               end
               default: begin
               end
            endcase
         end else if (left_ff != '0) begin
            push    = 1'b1;
            left_in = left_dec;
            if (frag_ff) begin
               if (fill_ff == '0) begin
                  vseq_in    = vseq_ff + 16'd1;
                  first_in   = 1'b0;
                  job.hdr    = 1'b1;
                  job.fu     = 1'b1;
                  job.seq    = vseq_in;
                  job.len    = flen + FU_HDR_LEN;
                  job.fu_ind = (nal_ff & 8'hE0) | FU_TYPE;
                  job.fu_hdr = (nal_ff & 8'h1F) |
                               (first_ff ? FU_START : (last_frag ? FU_END : 8'h00));
               end
               job.pend = frag_end;
               fill_in  = frag_end ? '0 : fill_nx;
               frag_in  = left_dec != '0;
            end else begin
               job.pend = left_dec == '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vseq_ff   <= '0;
         aseq_ff   <= '0;
         params_ff <= 1'b0;
         nal_ff    <= '0;
         left_ff   <= '0;
         fill_ff   <= '0;
         first_ff  <= 1'b0;
         frag_ff   <= 1'b0;
         ts_ff     <= '0;
      end else begin
         vseq_ff   <= vseq_in;
         aseq_ff   <= aseq_in;
         params_ff <= params_in;
         nal_ff    <= nal_in;
         left_ff   <= left_in;
         fill_ff   <= fill_in;
         first_ff  <= first_in;
         frag_ff   <= frag_in;
         ts_ff     <= ts_in;
      end
   end

endmodule

>>> hdl/rtpk_queue.sv
module rtpk_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rtpk_pkg::job_type wr_job,
   input  logic             pop,
   output rtpk_pkg::job_type head,
   output logic             head_valid,
   output logic             full
);
   import rtpk_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type        entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [PW:0]    count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign full       = count_ff == (PW+1)'(QUEUE_DEPTH);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wr_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> hdl/rtpk_back.sv
module rtpk_back (
   input  logic             clock,
   input  logic             reset,
   input  rtpk_pkg::job_type head,
   input  logic             head_valid,
   input  logic             interleaved_mode,
   input  logic [31:0]      ssrc_value,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rtpk_pkg::rsp_type rsp_data
);
   import rtpk_pkg::*;

   // byte positions within one request's burst
   localparam logic [4:0] POS_PREFIX  = 5'd0;
   localparam logic [4:0] POS_RTP     = 5'd4;
   localparam logic [4:0] POS_RTP_END = 5'd15;
   localparam logic [4:0] POS_AAC     = 5'd16;
   localparam logic [4:0] POS_FU      = 5'd18;
   localparam logic [4:0] POS_EXT_END = 5'd19;
   localparam logic [4:0] POS_PAYLOAD = 5'd20;

   logic       started_ff, started_in;
   logic [4:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic [4:0] start_pos;
   logic [4:0] pos;
   logic [4:0] next_pos;
   logic [7:0] cur_byte;
   logic       advance;

   assign start_pos = !head.hdr ? POS_PAYLOAD : (interleaved_mode ? POS_PREFIX : POS_RTP);
   assign pos       = started_ff ? pos_ff : start_pos;
   assign advance   = head_valid && (!valid_ff || !rsp_stall);
   assign pop       = advance && pos == POS_PAYLOAD;

   always_comb begin
      if (pos == POS_RTP_END) begin
         next_pos = head.aac ? POS_AAC : (head.fu ? POS_FU : POS_PAYLOAD);
      end else if (pos == POS_EXT_END) begin
         next_pos = POS_PAYLOAD;
      end else begin
         next_pos = pos + 5'd1;
      end
   end

   always_comb begin
      unique case (pos)
         5'd0:    cur_byte = PREFIX_MARK;
         5'd1:    cur_byte = head.audio ? CHAN_AUDIO : CHAN_VIDEO;
         5'd2:    cur_byte = head.len[15:8];
         5'd3:    cur_byte = head.len[7:0];
         5'd4:    cur_byte = RTP_VERSION;
         5'd5:    cur_byte = head.audio ? PT_AUDIO : PT_VIDEO;
         5'd6:    cur_byte = head.seq[15:8];
         5'd7:    cur_byte = head.seq[7:0];
         5'd8:    cur_byte = head.ts[31:24];
         5'd9:    cur_byte = head.ts[23:16];
         5'd10:   cur_byte = head.ts[15:8];
         5'd11:   cur_byte = head.ts[7:0];
         5'd12:   cur_byte = ssrc_value[31:24];
         5'd13:   cur_byte = ssrc_value[23:16];
         5'd14:   cur_byte = ssrc_value[15:8];
         5'd15:   cur_byte = ssrc_value[7:0];
         5'd16:   cur_byte = AU_HDR_LEN_HI;
         5'd17:   cur_byte = AU_HDR_LEN_LO;
         5'd18:   cur_byte = head.fu ? head.fu_ind : head.au_size[12:5];
         5'd19:   cur_byte = head.fu ? head.fu_hdr : {head.au_size[4:0], 3'b000};
         default: cur_byte = head.data;
      endcase
   end

   always_comb begin
      started_in = started_ff;
      pos_in     = pos_ff;
      valid_in   = valid_ff && rsp_stall;
      rsp_in     = rsp_ff;
      if (advance) begin
         valid_in            = 1'b1;
         rsp_in.out_byte     = cur_byte;
         rsp_in.packet_start = head.hdr && pos == start_pos;
         rsp_in.packet_end   = pos == POS_PAYLOAD && head.pend;
         rsp_in.last_of_run  = pos == POS_PAYLOAD;
         started_in          = pos != POS_PAYLOAD;
         pos_in              = next_pos;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         started_ff <= 1'b0;
         pos_ff     <= '0;
         valid_ff   <= 1'b0;
      end else begin
         started_ff <= started_in;
         pos_ff     <= pos_in;
         valid_ff   <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hdl/rtpk_checker.sv
module rtpk_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rtpk_pkg::rsp_type rsp_data
);
   `include "assert_macros.svh"

   // results are held while stalled
   `ASSERT_CLKD(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
   // nothing pending right after reset
   `ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid && !req_stall)
   // a packet only ends on a payload byte, which closes its request's burst
   `ASSERT_CLKD(a_end_closes_run, clock, reset, rsp_valid && rsp_data.packet_end |-> rsp_data.last_of_run)
   // a packet start is always a header byte, never the last of a burst
   `ASSERT_CLKD(a_start_not_last, clock, reset, rsp_valid && rsp_data.packet_start |-> !rsp_data.last_of_run)

endmodule

bind rtp_h264_aac_packetizer rtpk_checker u_rtpk_checker (
   .clock    (clock),
   .reset    (reset),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
